// ----- rtl/core/tsbb_pkg.sv -----
// tsbb_pkg: shared types, constants and helper functions of the tcp send byte buffer
// depends on: nothing
package tsbb_pkg;

  // store geometry
  localparam int CAPACITY = 4096;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int SLOT_W   = ADDR_W + 1;
  localparam int CNT_W    = 17;

  // port widths
  localparam int IN_TDATA_W  = 144;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 160;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  // configuration register index (paddr bit 2 and up)
  localparam logic REG_INITIAL_SEQUENCE = 1'b0;

  typedef enum logic [2:0] {
    ACT_WRITE     = 3'd0,
    ACT_PREP_NEW  = 3'd1,
    ACT_PREP_RETX = 3'd2,
    ACT_RETX_AT   = 3'd3,
    ACT_READ      = 3'd4,
    ACT_COMMIT    = 3'd5,
    ACT_ACK       = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ACK_NONE     = 2'd0,
    ACK_BEYOND   = 2'd1,
    ACK_DUP      = 2'd2,
    ACK_ADVANCED = 2'd3
  } ack_status_t;

  // input payload, last member in the lowest bits
  typedef struct packed {
    logic [6:0]  pad;
    logic [15:0] byte_index;
    logic        range_is_retx;
    logic [31:0] range_generation;
    logic [31:0] range_length;
    logic [15:0] max_payload;
    logic [31:0] seq_in;
    logic [7:0]  data_in;
  } in_item_t;

  // result payload, last member in the lowest bits
  typedef struct packed {
    logic [CNT_W-1:0] free_bytes;
    logic [CNT_W-1:0] unsent_bytes;
    logic [CNT_W-1:0] flight_octets;
    logic [CNT_W-1:0] newly_acked;
    logic [7:0]       data_out;
    logic             out_retx;
    logic [31:0]      out_generation;
    logic [15:0]      out_length;
    logic [31:0]      out_sequence;
    ack_status_t      ack_status;
    logic             ok;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_EXEC  = 2'd1,
    ST_RDATA = 2'd2
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic rd_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic read_hit;
  } dp_status_t;

  // serial order: a before b
  function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  // circular slot, head < CAPACITY and off <= CAPACITY
  function automatic logic [ADDR_W-1:0] slot(input logic [ADDR_W-1:0] head,
                                             input logic [SLOT_W-1:0] off);
    logic [SLOT_W-1:0] s;
    s = {1'b0, head} + off;
    if (s >= SLOT_W'(CAPACITY)) begin
      s = s - SLOT_W'(CAPACITY);
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage

// ----- rtl/core/tsbb_ctrl.sv -----
// tsbb_ctrl: sequencer for one transaction at a time and output valid tracking
// depends on: tsbb_pkg
module tsbb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output tsbb_pkg::ctrl_cmd_t cmd,
  input  tsbb_pkg::dp_status_t status
);
  import tsbb_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  // state and valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    in_tready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd.exec = 1'b1;
          if (status.read_hit) begin
            state_nxt = ST_RDATA;
          end else begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      ST_RDATA: begin
        cmd.rd_load   = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/tsbb_datapath.sv -----
// tsbb_datapath: sequence pointers, byte store, range checks and result register
// depends on: tsbb_pkg
module tsbb_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tsbb_pkg::ctrl_cmd_t               cmd,
  output tsbb_pkg::dp_status_t              status,
  input  logic [tsbb_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [tsbb_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic [tsbb_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_we,
  input  logic [tsbb_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [tsbb_pkg::CFG_DW-1:0]       cfg_wdata,
  output logic [tsbb_pkg::CFG_DW-1:0]       cfg_rdata
);
  import tsbb_pkg::*;

  // captured item
  in_item_t item_r;
  action_t  action_r;

  // buffer state
  logic [31:0]       init_seq_r;
  logic [31:0]       una_r, una_nxt;
  logic [31:0]       nsn_r, nsn_nxt;
  logic [31:0]       wend_r, wend_nxt;
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [31:0]       gen_r, gen_nxt;

  // byte store
  logic [7:0]        mem [CAPACITY];
  logic [7:0]        rd_data_r;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  result_t res_r, res_nxt;

  // working values
  logic [31:0] flight, unsent, queued, writable;
  logic [31:0] r_off, ack_newly, retx_span;
  logic [31:0] f_after, u_after, q_after;
  logic        range_ok;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r   <= in_item_t'(in_tdata);
      action_r <= action_t'(in_tuser);
    end
  end

  // counts before the step
  assign flight   = nsn_r - una_r;
  assign unsent   = wend_r - nsn_r;
  assign queued   = wend_r - una_r;
  assign writable = 32'(CAPACITY) - queued;

  // is the presented range still current
  assign r_off = item_r.seq_in - una_r;
  always_comb begin
    range_ok = (item_r.range_length != 32'd0) && (item_r.range_generation == gen_r)
               && (r_off < queued) && (item_r.range_length <= queued - r_off);
    if (item_r.range_is_retx) begin
      range_ok = range_ok && (r_off < flight) && (item_r.range_length <= flight - r_off);
    end else begin
      range_ok = range_ok && (item_r.seq_in == nsn_r) && (item_r.range_length <= unsent);
    end
  end

  assign status.read_hit = (action_r == ACT_READ) && range_ok
                           && ({16'd0, item_r.byte_index} < item_r.range_length);

  assign ack_newly = item_r.seq_in - una_r;
  assign retx_span = nsn_r - item_r.seq_in;
  assign wr_addr   = slot(head_r, SLOT_W'(queued));
  assign rd_addr   = slot(head_r, SLOT_W'(r_off) + SLOT_W'(item_r.byte_index));

  // action decode
  always_comb begin
    una_nxt  = una_r;
    nsn_nxt  = nsn_r;
    wend_nxt = wend_r;
    head_nxt = head_r;
    gen_nxt  = gen_r;
    mem_we   = 1'b0;
    res_nxt  = '0;
    case (action_r)
      ACT_WRITE: begin
        if (writable != 32'd0) begin
          mem_we     = 1'b1;
          wend_nxt   = wend_r + 32'd1;
          gen_nxt    = gen_r + 32'd1;
          res_nxt.ok = 1'b1;
        end
      end
      ACT_PREP_NEW: begin
        if (item_r.max_payload != 16'd0) begin
          res_nxt.out_sequence   = nsn_r;
          res_nxt.out_length     = (unsent < {16'd0, item_r.max_payload}) ?
                                   unsent[15:0] : item_r.max_payload;
          res_nxt.out_generation = gen_r;
        end
      end
      ACT_PREP_RETX: begin
        if (item_r.max_payload != 16'd0) begin
          res_nxt.out_sequence   = una_r;
          res_nxt.out_length     = (flight < {16'd0, item_r.max_payload}) ?
                                   flight[15:0] : item_r.max_payload;
          res_nxt.out_generation = gen_r;
          res_nxt.out_retx       = 1'b1;
        end
      end
      ACT_RETX_AT: begin
        if ((item_r.max_payload != 16'd0) && !seq_before(item_r.seq_in, una_r)
            && seq_before(item_r.seq_in, nsn_r)) begin
          res_nxt.out_sequence   = item_r.seq_in;
          res_nxt.out_length     = (retx_span < {16'd0, item_r.max_payload}) ?
                                   retx_span[15:0] : item_r.max_payload;
          res_nxt.out_generation = gen_r;
          res_nxt.out_retx       = 1'b1;
        end
      end
      ACT_READ: begin
        res_nxt.ok = status.read_hit;
      end
      ACT_COMMIT: begin
        if (range_ok) begin
          if (!item_r.range_is_retx) begin
            nsn_nxt = nsn_r + item_r.range_length;
          end
          gen_nxt    = gen_r + 32'd1;
          res_nxt.ok = 1'b1;
        end
      end
      ACT_ACK: begin
        if (seq_before(nsn_r, item_r.seq_in)) begin
          res_nxt.ack_status = ACK_BEYOND;
        end else if (!seq_before(una_r, item_r.seq_in)) begin
          res_nxt.ack_status = ACK_DUP;
        end else begin
          res_nxt.newly_acked = ack_newly[CNT_W-1:0];
          head_nxt            = slot(head_r, SLOT_W'(ack_newly));
          una_nxt             = item_r.seq_in;
          gen_nxt             = gen_r + 32'd1;
          res_nxt.ack_status  = ACK_ADVANCED;
        end
      end
      default: begin
        res_nxt = '0;
      end
    endcase
    // counts after the step
    f_after = nsn_nxt - una_nxt;
    u_after = wend_nxt - nsn_nxt;
    q_after = wend_nxt - una_nxt;
    res_nxt.flight_octets = f_after[CNT_W-1:0];
    res_nxt.unsent_bytes  = u_after[CNT_W-1:0];
    res_nxt.free_bytes    = CNT_W'(32'(CAPACITY) - q_after);
  end

  // pointer registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_seq_r <= '0;
      una_r      <= '0;
      nsn_r      <= '0;
      wend_r     <= '0;
      head_r     <= '0;
      gen_r      <= '0;
    end else if (cfg_we) begin
      if (cfg_addr[CFG_AW-1] == REG_INITIAL_SEQUENCE) begin
        init_seq_r <= cfg_wdata;
        una_r      <= cfg_wdata;
        nsn_r      <= cfg_wdata;
        wend_r     <= cfg_wdata;
      end
    end else if (cmd.exec) begin
      una_r  <= una_nxt;
      nsn_r  <= nsn_nxt;
      wend_r <= wend_nxt;
      head_r <= head_nxt;
      gen_r  <= gen_nxt;
    end
  end

  assign cfg_rdata = (cfg_addr[CFG_AW-1] == REG_INITIAL_SEQUENCE) ? init_seq_r : '0;

  // byte store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[wr_addr] <= item_r.data_in;
    end
    if (cmd.exec && status.read_hit) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_r <= res_nxt;
    end else if (cmd.rd_load) begin
      res_r.data_out <= rd_data_r;
    end
  end

  assign out_tdata = OUT_TDATA_W'(res_r);

endmodule

// ----- rtl/core/tcp_send_byte_buffer_core.sv -----
// tcp send byte buffer, top level: controller, datapath and configuration port
// an item is accepted in idle, executed once the output register is free, and its result
// is held in an output register; a byte read passes a further state that loads the byte
// (the store read is registered); a new item is accepted only once the last is through
// reset (rst_n low, synchronous) clears pointers, head, generation and the register to 0
// depends on: tsbb_pkg, tsbb_ctrl, tsbb_datapath
module tcp_send_byte_buffer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // data_in, seq_in, max_payload, range_length, range_generation, range_is_retx,
  // byte_index, zero pad
  input  logic [tsbb_pkg::IN_TDATA_W-1:0]   in_tdata,
  // action
  input  logic [tsbb_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // ok, ack_status, out_sequence, out_length, out_generation, out_retx, data_out,
  // newly_acked, flight_octets, unsent_bytes, free_bytes
  output logic [tsbb_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [tsbb_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [tsbb_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [tsbb_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                              cfg_pready
);
  import tsbb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       cfg_we;

  // configuration write strobe
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  tsbb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  tsbb_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_paddr),
    .cfg_wdata (cfg_pwdata),
    .cfg_rdata (cfg_prdata)
  );

endmodule

// ----- rtl/core/tsbb_checker.sv -----
// tsbb_checker: port-level checks of the tcp send byte buffer, bound to the top level
// depends on: tsbb_pkg, tcp_send_byte_buffer_core
module tsbb_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [tsbb_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import tsbb_pkg::*;

  result_t          res;
  logic [CNT_W:0]   count_sum;

  assign res       = result_t'(out_tdata);
  assign count_sum = {1'b0, res.flight_octets} + {1'b0, res.unsent_bytes}
                     + {1'b0, res.free_bytes};

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // one transaction in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction accepted during execution");

  // queued plus free space always equals the store size
  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> count_sum == (CNT_W + 1)'(CAPACITY))
    else $error("flight, unsent and writable do not add up to capacity");

  // an ack result carries no range and no ok
  a_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res.ack_status != ACK_NONE) |->
      !res.ok && (res.out_length == 16'd0) && !res.out_retx)
    else $error("ack result mixed with range fields");

endmodule

bind tcp_send_byte_buffer_core tsbb_checker u_tsbb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
